// ----- design/rgb_color_distance_macros.svh -----
// assertion macros for the rgb color distance checker
// expects clk_i and rst_ni in the scope of the use
`ifndef RGB_COLOR_DISTANCE_MACROS_SVH
`define RGB_COLOR_DISTANCE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_color_distance: check failed");

// next-cycle implication, disabled in reset
`define RCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_color_distance: check failed");

`endif

// ----- design/rcd_pkg.sv -----
// shared types, constants and width helpers of the rgb color distance block
// no dependencies
`default_nettype none

package rcd_pkg;

  localparam int unsigned VALUE_W    = 13;
  localparam int unsigned THRESH_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MASK_ON    = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_RED    = 3'd0,
    CFG_REF_GREEN  = 3'd1,
    CFG_REF_BLUE   = 3'd2,
    CFG_MODE       = 3'd3,
    CFG_THRESH_SQ  = 3'd4
  } cfg_idx_e;

  // squared distance of three channels
  function automatic int unsigned sum_width(int unsigned chan_bits);
    return 2 * chan_bits + 2;
  endfunction

  // bits of the fixed-point root
  function automatic int unsigned root_width(int unsigned chan_bits, int unsigned frac_bits);
    return (sum_width(chan_bits) + 2 * frac_bits + 1) / 2;
  endfunction

  // accept to result strobe, in cycles
  function automatic int unsigned latency(int unsigned chan_bits, int unsigned frac_bits);
    return 3 + root_width(chan_bits, frac_bits);
  endfunction

endpackage

`default_nettype wire

// ----- design/rgb_color_distance.sv -----
// rgb color distance: squared distance, threshold mask and pipelined square root
// depends on rcd_pkg
`default_nettype none

// One pixel is taken in every clock cycle (busy stays low) and each pixel gives
// exactly one beat on value_o, marked by valid_o for one cycle, in input order.
// The pipeline has one stage for the channel differences, one for the squares,
// one for the sum and threshold compare, then the square root takes one result
// bit per pipeline stage. Results cannot be held off, so the receiver must take
// every beat. The user must write configuration through cfg_we_i/cfg_idx_i/
// cfg_data_i only while no pixel is in flight; the block does not enforce this.
module rgb_color_distance #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [CHANNEL_BITS-1:0]       pixel_red_i,
  input  wire logic [CHANNEL_BITS-1:0]       pixel_green_i,
  input  wire logic [CHANNEL_BITS-1:0]       pixel_blue_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [((CHANNEL_BITS > rcd_pkg::THRESH_W) ?
                      CHANNEL_BITS : rcd_pkg::THRESH_W)-1:0] cfg_data_i,
  output logic                               valid_o,
  output logic [rcd_pkg::VALUE_W-1:0]        value_o
);

  localparam int unsigned C       = CHANNEL_BITS;
  localparam int unsigned SQ_W    = 2 * C;
  localparam int unsigned SUM_W   = rcd_pkg::sum_width(C);
  localparam int unsigned ROOT_W  = rcd_pkg::root_width(C, FRACTION_BITS);
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned CMP_W   = (SUM_W > rcd_pkg::THRESH_W) ? SUM_W : rcd_pkg::THRESH_W;
  localparam int unsigned EXT_W   = (ROOT_W > rcd_pkg::VALUE_W) ? ROOT_W : rcd_pkg::VALUE_W;

  // configuration registers
  logic [C-1:0]                  ref_red_q, ref_green_q, ref_blue_q;
  logic                          mode_q;
  logic [rcd_pkg::THRESH_W-1:0]  thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_red_q   <= '0;
      ref_green_q <= '0;
      ref_blue_q  <= '0;
      mode_q      <= 1'b1;
      thresh_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (rcd_pkg::cfg_idx_e'(cfg_idx_i))
        rcd_pkg::CFG_REF_RED:   ref_red_q   <= cfg_data_i[C-1:0];
        rcd_pkg::CFG_REF_GREEN: ref_green_q <= cfg_data_i[C-1:0];
        rcd_pkg::CFG_REF_BLUE:  ref_blue_q  <= cfg_data_i[C-1:0];
        rcd_pkg::CFG_MODE:      mode_q      <= cfg_data_i[0];
        rcd_pkg::CFG_THRESH_SQ: thresh_q    <= cfg_data_i[rcd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: absolute channel differences
  logic         v1_q;
  logic [C-1:0] dr_q, dg_q, db_q;
  logic [C-1:0] dr_d, dg_d, db_d;

  always_comb begin
    dr_d = (ref_red_q   >= pixel_red_i)   ? ref_red_q   - pixel_red_i
                                          : pixel_red_i   - ref_red_q;
    dg_d = (ref_green_q >= pixel_green_i) ? ref_green_q - pixel_green_i
                                          : pixel_green_i - ref_green_q;
    db_d = (ref_blue_q  >= pixel_blue_i)  ? ref_blue_q  - pixel_blue_i
                                          : pixel_blue_i  - ref_blue_q;
  end

  // stage 2: squares
  logic            v2_q;
  logic [SQ_W-1:0] sr_q, sg_q, sb_q;

  // stage 3 feeds root stage 0 through the arrays below
  logic [SUM_W-1:0] sum_d;
  logic             lt_d;
  logic [RAD_W-1:0] rad_d;

  always_comb begin
    sum_d = SUM_W'(sr_q) + SUM_W'(sg_q) + SUM_W'(sb_q);
    lt_d  = CMP_W'(sum_d) < CMP_W'(thresh_q);
    rad_d = RAD_W'(sum_d) << (2 * FRACTION_BITS);
  end

  logic              vld_q  [ROOT_W+1];
  logic              lt_q   [ROOT_W+1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      v1_q     <= accept;
      v2_q     <= v1_q;
      vld_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q      <= dr_d;
    dg_q      <= dg_d;
    db_q      <= db_d;
    sr_q      <= SQ_W'(dr_q) * SQ_W'(dr_q);
    sg_q      <= SQ_W'(dg_q) * SQ_W'(dg_q);
    sb_q      <= SQ_W'(db_q) * SQ_W'(db_q);
    lt_q[0]   <= lt_d;
    rad_q[0]  <= rad_d;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      rem_sh = {rem_q[k][ROOT_W-1:0], rad_q[k][RAD_W-1 -: 2]};
      trial  = {root_q[k], 2'b01};
      ge     = rem_sh >= trial;
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_q[k][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      lt_q[k+1]   <= lt_q[k];
      rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
    end
  end

  logic [EXT_W-1:0] root_ext;
  assign root_ext = EXT_W'(root_q[ROOT_W]);

  always_comb begin
    if (mode_q) begin
      value_o = lt_q[ROOT_W] ? rcd_pkg::VALUE_W'(rcd_pkg::MASK_ON) : '0;
    end else begin
      value_o = root_ext[rcd_pkg::VALUE_W-1:0];
    end
  end

  assign valid_o = vld_q[ROOT_W];

endmodule

`default_nettype wire

// ----- design/rcd_checker.sv -----
// port-level checker for rgb_color_distance, attached by bind
// depends on rcd_pkg and rgb_color_distance_macros.svh
`default_nettype none
`include "rgb_color_distance_macros.svh"

module rcd_checker #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [((CHANNEL_BITS > rcd_pkg::THRESH_W) ?
                      CHANNEL_BITS : rcd_pkg::THRESH_W)-1:0] cfg_data_i,
  input  wire logic                          valid_o,
  input  wire logic [rcd_pkg::VALUE_W-1:0]   value_o
);

  localparam int unsigned LAT = rcd_pkg::latency(CHANNEL_BITS, FRACTION_BITS);

  // mode as last written on the port
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i && cfg_idx_i == rcd_pkg::CFG_MODE) begin
      mode_q <= cfg_data_i[0];
    end
  end

  logic accept;
  assign accept = start && !busy;

  // every pixel yields a beat after the fixed latency
  `RCD_ASSERT_IMPL(a_beat_follows, accept, ##LAT valid_o)
  // no beat without a pixel taken at the matching edge
  `RCD_ASSERT_IMPL(a_beat_has_pixel, valid_o, $past(accept, LAT))
  // mask beats only carry 0 or 255
  `RCD_ASSERT_IMPL(a_mask_value, valid_o && mode_q,
                   value_o == '0 || value_o == rcd_pkg::VALUE_W'(rcd_pkg::MASK_ON))
  // the block never stalls the sender
  `RCD_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

bind rgb_color_distance rcd_checker #(
  .CHANNEL_BITS (CHANNEL_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_rcd_checker (.*);

`default_nettype wire
